[rtl/awsc_pkg.sv]
package awsc_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int MAX_SAMPLES = 256;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W       = $clog2(4095 * MAX_SAMPLES + 1);
  localparam int MEAN_W      = SAMPLE_W;
  localparam int ACC_W       = CNT_W + MEAN_W;
  localparam int STEP_W      = $clog2(MEAN_W);
  localparam int CLASS_W     = 3;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE    = 12'd4095;
  localparam logic [SAMPLE_W-1:0] NEAR_ZERO_MAX = 12'd8;
  localparam logic [SAMPLE_W-1:0] NEAR_FULL_MIN = 12'd4087;
  localparam logic [SAMPLE_W-1:0] SPAN_STABLE   = 12'd4;
  localparam logic [SAMPLE_W-1:0] SPAN_SMALL    = 12'd24;
  localparam logic [SAMPLE_W-1:0] SPAN_ACTIVE   = 12'd120;
  localparam logic [SAMPLE_W-1:0] RAIL_HIGH     = 12'd3500;
  localparam logic [SAMPLE_W-1:0] RAIL_LOW      = 12'd500;

  typedef enum logic [CLASS_W-1:0] {
    CLS_NEAR_ZERO = 3'd0,
    CLS_NEAR_FULL = 3'd1,
    CLS_STABLE    = 3'd2,
    CLS_SMALL_VAR = 3'd3,
    CLS_ACTIVE    = 3'd4,
    CLS_WIDE_RAIL = 3'd5,
    CLS_FLOATING  = 3'd6
  } class_t;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic accum;
    logic close;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic close_hit;
    logic div_last;
  } sts_t;

  function automatic class_t classify(input logic [SAMPLE_W-1:0] lo,
                                      input logic [SAMPLE_W-1:0] hi,
                                      input logic [SAMPLE_W-1:0] avg);
    logic [SAMPLE_W-1:0] span;
    class_t              cls;
    span = hi - lo;
    if (hi <= NEAR_ZERO_MAX) cls = CLS_NEAR_ZERO;
    else if (lo >= NEAR_FULL_MIN) cls = CLS_NEAR_FULL;
    else if (span <= SPAN_STABLE) cls = CLS_STABLE;
    else if (span <= SPAN_SMALL) cls = CLS_SMALL_VAR;
    else if (span <= SPAN_ACTIVE) cls = CLS_ACTIVE;
    else if (avg > RAIL_HIGH || avg < RAIL_LOW) cls = CLS_WIDE_RAIL;
    else cls = CLS_FLOATING;
    return cls;
  endfunction

endpackage

[rtl/awsc_ctrl.sv]
module awsc_ctrl import awsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   in_xfer;
  logic   out_free;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCUM: begin
        if (in_xfer && sts.close_hit) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (sts.div_last) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_next = ST_ACCUM;
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd.accum    = 1'b0;
    cmd.close    = 1'b0;
    cmd.div_step = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      ST_ACCUM: begin
        in_stall  = 1'b0;
        cmd.accum = in_valid;
        cmd.close = in_valid && sts.close_hit;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_HOLD: begin
        cmd.load_out = out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // result register empties on an output transfer, refills from the divider
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) out_valid_next = 1'b0;
    if (cmd.load_out) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/awsc_dp.sv]
module awsc_dp import awsc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                window_end,
  output logic [SAMPLE_W-1:0] final_sample,
  output logic [SAMPLE_W-1:0] lowest,
  output logic [SAMPLE_W-1:0] highest,
  output logic [MEAN_W-1:0]   mean,
  output logic [SAMPLE_W-1:0] spread,
  output logic [CLASS_W-1:0]  class_code
);

  logic [SAMPLE_W-1:0] run_min;
  logic [SAMPLE_W-1:0] run_max;
  logic [SUM_W-1:0]    run_sum;
  logic [CNT_W-1:0]    run_count;

  logic [SAMPLE_W-1:0] min_next;
  logic [SAMPLE_W-1:0] max_next;
  logic [SUM_W-1:0]    sum_next;
  logic [CNT_W-1:0]    count_next;

  // snapshot of the closed window
  logic [SAMPLE_W-1:0] snap_fin;
  logic [SAMPLE_W-1:0] snap_lo;
  logic [SAMPLE_W-1:0] snap_hi;
  logic [CNT_W-1:0]    div_cnt;

  // {remainder, dividend bits / quotient bits}
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    acc_next;
  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      diff;
  logic                q_bit;
  logic [CNT_W-1:0]    rem_next;
  logic [STEP_W-1:0]   step;

  assign min_next   = (sample < run_min) ? sample : run_min;
  assign max_next   = (sample > run_max) ? sample : run_max;
  assign sum_next   = run_sum + SUM_W'(sample);
  assign count_next = run_count + 1'b1;

  assign sts.close_hit = window_end || (count_next == CNT_W'(MAX_SAMPLES));
  assign sts.div_last  = (step == STEP_W'(MEAN_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min   <= FULL_SCALE;
      run_max   <= '0;
      run_sum   <= '0;
      run_count <= '0;
    end else if (cmd.accum) begin
      if (cmd.close) begin
        run_min   <= FULL_SCALE;
        run_max   <= '0;
        run_sum   <= '0;
        run_count <= '0;
      end else begin
        run_min   <= min_next;
        run_max   <= max_next;
        run_sum   <= sum_next;
        run_count <= count_next;
      end
    end
  end

  // restoring divide, one quotient bit a cycle; mean < 2^MEAN_W keeps remainder < count
  assign trial    = acc[ACC_W-1:MEAN_W-1];
  assign diff     = trial - {1'b0, div_cnt};
  assign q_bit    = (trial >= {1'b0, div_cnt});
  assign rem_next = q_bit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  assign acc_next = {rem_next, acc[MEAN_W-2:0], q_bit};

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      snap_fin <= sample;
      snap_lo  <= min_next;
      snap_hi  <= max_next;
      div_cnt  <= count_next;
      acc      <= ACC_W'(sum_next);
    end else if (cmd.div_step) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.close) begin
      step <= '0;
    end else if (cmd.div_step) begin
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      final_sample <= snap_fin;
      lowest       <= snap_lo;
      highest      <= snap_hi;
      mean         <= acc[MEAN_W-1:0];
      spread       <= snap_hi - snap_lo;
      class_code   <= CLASS_W'(classify(snap_lo, snap_hi, acc[MEAN_W-1:0]));
    end
  end

endmodule

[rtl/analog_window_stats_classifier_core.sv]
// Window statistics for a 12-bit ADC channel. Samples are taken one per cycle while a
// window is open; the running minimum, maximum, sum and count update on every transfer.
// A window closes on a sample with window_end set, or on the MAX_SAMPLES-th sample.
// The closing sample is followed by the divide state, where a restore-and-subtract divider
// forms one bit of the mean per cycle, and the hold state, which loads the result register,
// so in_stall is high from each closing sample until the result register is loaded. The
// result register holds the last window's values until taken, and accumulation of the next
// window goes on meanwhile; the block waits in the hold state with in_stall high only while
// the previous result has still not been taken.
module analog_window_stats_classifier_core import awsc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                window_end,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] final_sample,
  output logic [SAMPLE_W-1:0] lowest,
  output logic [SAMPLE_W-1:0] highest,
  output logic [MEAN_W-1:0]   mean,
  output logic [SAMPLE_W-1:0] spread,
  output logic [CLASS_W-1:0]  class_code
);

  cmd_t cmd;
  sts_t sts;

  awsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  awsc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .sample       (sample),
    .window_end   (window_end),
    .final_sample (final_sample),
    .lowest       (lowest),
    .highest      (highest),
    .mean         (mean),
    .spread       (spread),
    .class_code   (class_code)
  );

endmodule

[dv/tb_analog_window_stats_classifier_core.sv]
module tb_analog_window_stats_classifier_core import awsc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1450;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic                closes;
  } adc_item_t;

  typedef struct {
    logic [SAMPLE_W-1:0] final_sample;
    logic [SAMPLE_W-1:0] lowest;
    logic [SAMPLE_W-1:0] highest;
    logic [MEAN_W-1:0]   mean;
    logic [SAMPLE_W-1:0] spread;
    class_t              cls;
  } window_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                window_end = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SAMPLE_W-1:0] final_sample;
  logic [SAMPLE_W-1:0] lowest;
  logic [SAMPLE_W-1:0] highest;
  logic [MEAN_W-1:0]   mean;
  logic [SAMPLE_W-1:0] spread;
  logic [CLASS_W-1:0]  class_code;

  adc_item_t      adc_items_q[$];
  window_result_t window_results_q[$];

  // running window statistics, same reset values as the block
  logic [SAMPLE_W-1:0] run_low = FULL_SCALE;
  logic [SAMPLE_W-1:0] run_high = '0;
  logic [SUM_W-1:0]    run_total = '0;
  logic [CNT_W-1:0]    run_samples = '0;

  logic in_took = 1'b0;
  int   total_items = 0;
  int   accepted_count = 0;
  int   windows_checked = 0;
  int   full_closes = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  int   class_hits[7];

  analog_window_stats_classifier_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .window_end   (window_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .final_sample (final_sample),
    .lowest       (lowest),
    .highest      (highest),
    .mean         (mean),
    .spread       (spread),
    .class_code   (class_code)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic class_t expected_class(logic [SAMPLE_W-1:0] lo, logic [SAMPLE_W-1:0] hi,
                                            logic [MEAN_W-1:0] avg);
    logic [SAMPLE_W-1:0] span;
    span = hi - lo;
    if (hi <= NEAR_ZERO_MAX) return CLS_NEAR_ZERO;
    if (lo >= NEAR_FULL_MIN) return CLS_NEAR_FULL;
    if (span <= SPAN_STABLE) return CLS_STABLE;
    if (span <= SPAN_SMALL) return CLS_SMALL_VAR;
    if (span <= SPAN_ACTIVE) return CLS_ACTIVE;
    if (avg > RAIL_HIGH || avg < RAIL_LOW) return CLS_WIDE_RAIL;
    return CLS_FLOATING;
  endfunction

  task automatic accumulate_sample(adc_item_t item);
    window_result_t res;
    if (item.value < run_low) run_low = item.value;
    if (item.value > run_high) run_high = item.value;
    run_total = run_total + item.value;
    run_samples = run_samples + 1'b1;
    if (item.closes || run_samples == MAX_SAMPLES) begin
      if (!item.closes) full_closes++;
      res.final_sample = item.value;
      res.lowest       = run_low;
      res.highest      = run_high;
      res.mean         = MEAN_W'(run_total / run_samples);
      res.spread       = run_high - run_low;
      res.cls          = expected_class(run_low, run_high, res.mean);
      window_results_q.push_back(res);
      run_low     = FULL_SCALE;
      run_high    = '0;
      run_total   = '0;
      run_samples = '0;
    end
  endtask

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0d ns: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_sample(int unsigned value, bit closes);
    adc_item_t item;
    item.value  = SAMPLE_W'(value);
    item.closes = closes;
    adc_items_q.push_back(item);
  endtask

  // one window of len samples; content style picked per window to reach every class
  task automatic queue_window(int len, bit close_flag);
    int          style;
    int unsigned lim;
    int unsigned base;
    int unsigned value;
    bit          upper;
    int unsigned lims[6] = '{4, 5, 24, 25, 120, 121};
    style = $urandom_range(5);
    lim   = lims[$urandom_range(5)] + (($urandom_range(3) == 0) ? $urandom_range(200) : 0);
    base  = $urandom_range(4095 - lim);
    upper = $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      case (style)
        0: value = $urandom_range(4095);
        1: value = $urandom_range(12);
        2: value = $urandom_range(4095, 4083);
        5: value = upper ? $urandom_range(4095, 3100) : $urandom_range(900);
        default: value = base + $urandom_range(lim);
      endcase
      push_sample(value, close_flag && (i == len - 1));
    end
  endtask

  // sender: holds the payload until the transfer happens
  always @(negedge clk) begin : drive
    adc_item_t next_item;
    int        send_idle;
    int        recv_idle;
    if (!rst) begin
      if (accepted_count < total_items / 3) begin
        send_idle = 20;
        recv_idle = 67;
      end else if (accepted_count < 2 * total_items / 3) begin
        send_idle = 67;
        recv_idle = 20;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (!in_valid || in_took) begin
        if (adc_items_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_item = adc_items_q.pop_front();
          in_valid   <= 1'b1;
          sample     <= next_item.value;
          window_end <= next_item.closes;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin : observe
    adc_item_t      got_item;
    window_result_t want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        got_item.value  = sample;
        got_item.closes = window_end;
        accumulate_sample(got_item);
        accepted_count++;
      end
      if (out_valid && !out_stall) begin
        if (window_results_q.size() == 0) begin
          $display("%0d ns: result with none expected: last %0d min %0d max %0d mean %0d",
                   $time, final_sample, lowest, highest, mean);
          mismatches++;
        end else begin
          want = window_results_q.pop_front();
          check_field("final_sample", want.final_sample, final_sample);
          check_field("lowest", want.lowest, lowest);
          check_field("highest", want.highest, highest);
          check_field("mean", want.mean, mean);
          check_field("spread", want.spread, spread);
          check_field("class_code", want.cls, class_code);
          class_hits[want.cls]++;
          windows_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d of %0d samples sent, %0d results pending",
               cycle_count, accepted_count, total_items, window_results_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    int pick;
    int directed_items;
    // rails and threshold edges, one class boundary per window
    push_sample(0, 1);
    push_sample(4095, 1);
    push_sample(8, 1);
    push_sample(9, 1);
    push_sample(4087, 1);
    push_sample(4086, 1);
    push_sample(2000, 0); push_sample(2004, 1);
    push_sample(2000, 0); push_sample(2005, 1);
    push_sample(1000, 0); push_sample(1025, 1);
    push_sample(1000, 0); push_sample(1120, 1);
    push_sample(3400, 0); push_sample(3600, 1);
    push_sample(200, 0);  push_sample(0, 1);
    push_sample(400, 0);  push_sample(600, 1);
    push_sample(399, 0);  push_sample(599, 1);
    push_sample(3401, 0); push_sample(3601, 1);
    directed_items = adc_items_q.size();

    while (adc_items_q.size() < directed_items + RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 2) queue_window(MAX_SAMPLES, 1'b0);                   // closes on count
      else if (pick < 3) queue_window(MAX_SAMPLES, 1'b1);              // count and flag together
      else if (pick < 5) queue_window($urandom_range(MAX_SAMPLES + 40, MAX_SAMPLES + 1), 1'b1);
      else if (pick < 12) queue_window($urandom_range(8, 1), 1'b0);    // runs into next window
      else queue_window($urandom_range(12, 1), 1'b1);
    end
    push_sample($urandom_range(4095), 1);
    total_items = adc_items_q.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_count < total_items || window_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d samples in %0d windows checked, %0d closed by the sample limit",
             accepted_count, windows_checked, full_closes);
    $display("class codes 0..6 seen: %0d %0d %0d %0d %0d %0d %0d", class_hits[0],
             class_hits[1], class_hits[2], class_hits[3], class_hits[4], class_hits[5],
             class_hits[6]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
rtl/awsc_pkg.sv
rtl/awsc_ctrl.sv
rtl/awsc_dp.sv
rtl/analog_window_stats_classifier_core.sv
dv/tb_analog_window_stats_classifier_core.sv
